/* hdl/ced_pkg.sv */
// ----------------------------------------------------------------------------
// ced_pkg
// shared types, mode codes and helpers for the escape sequence decoder
// ----------------------------------------------------------------------------
package ced_pkg;

    localparam int C_CHAR_BITS = 16;
    localparam logic [15:0] C_CHAR_MASK =
        (C_CHAR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << C_CHAR_BITS) - 32'd1);

    localparam int C_Q_DEPTH = 4;
    localparam int C_Q_AW    = $clog2(C_Q_DEPTH);

    localparam logic [2:0] C_MODE_IDLE = 3'd0;
    localparam logic [2:0] C_MODE_ESC  = 3'd1;
    localparam logic [2:0] C_MODE_OCT  = 3'd2;
    localparam logic [2:0] C_MODE_HEX2 = 3'd3;
    localparam logic [2:0] C_MODE_HEX4 = 3'd4;

    localparam logic [2:0] C_LIMIT_OCT  = 3'd3;
    localparam logic [2:0] C_LIMIT_HEX2 = 3'd2;
    localparam logic [2:0] C_LIMIT_HEX4 = 3'd4;

    typedef struct packed {
        logic [15:0] in_char;
        logic        end_of_input;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] out_char;
        logic        char_valid;
        logic        end_of_output;
    } t_out_beat;

    // classified input beat
    typedef struct packed {
        logic [15:0] ch;
        logic        eoi;
        logic        is_bslash;
        logic [15:0] esc_code;
        logic        is_zero;
        logic        is_x;
        logic        is_u;
        logic        oct_ok;
        logic [2:0]  oct_val;
        logic        hex_ok;
        logic [3:0]  hex_val;
    } t_cls;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic      has_res;
        logic      go_esc;
        t_out_beat beat;
    } t_idle_res;

    function automatic t_out_beat mask_beat(t_out_beat b);
        t_out_beat r;
        r          = b;
        r.out_char = b.out_char & C_CHAR_MASK;
        return r;
    endfunction

    function automatic t_idle_res idle_step(t_cls c);
        t_idle_res r;
        r = '0;
        if (c.is_bslash) begin
            if (c.eoi) begin
                r.has_res = 1'b1;
                r.beat    = '{out_char: 16'd0, char_valid: 1'b0, end_of_output: 1'b1};
            end else begin
                r.go_esc = 1'b1;
            end
        end else begin
            r.has_res = 1'b1;
            r.beat    = '{out_char: c.ch, char_valid: 1'b1, end_of_output: c.eoi};
        end
        return r;
    endfunction

endpackage

/* hdl/c_escape_sequence_decoder.sv */
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder
// result path: each input beat is written into the queue, then popped into
// the output register, from which the result beat can be taken
// throughput: one input beat per cycle while the queue is not full; a beat
// that yields two results holds its second one in a pending register
// reset: synchronous, clears escape state, queue and output register
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder import ced_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    t_cls      w_cls;
    t_cls      w_head;
    t_q_status w_status;
    logic      w_push;
    logic      w_pop;

    assign o_in_ready = !w_status.full;
    assign w_push     = i_in_valid && o_in_ready;

    ced_front u_front (
        .i_in_beat (i_in_beat),
        .o_cls     (w_cls)
    );

    ced_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_wdata  (w_cls),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    ced_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_status    (w_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

/* hdl/ced_front.sv */
// ----------------------------------------------------------------------------
// ced_front
// classifies each input character: backslash, escape letters, digit values
// ----------------------------------------------------------------------------
module ced_front import ced_pkg::*; (
    input  t_in_beat i_in_beat,
    output t_cls     o_cls
);

    logic [15:0] w_c;

    assign w_c = i_in_beat.in_char;

    always_comb begin
        o_cls           = '0;
        o_cls.ch        = w_c;
        o_cls.eoi       = i_in_beat.end_of_input;
        o_cls.is_bslash = (w_c == 16'h005C);
        o_cls.is_zero   = (w_c == 16'h0030);
        o_cls.is_x      = (w_c == 16'h0078);
        o_cls.is_u      = (w_c == 16'h0075);
        o_cls.oct_ok    = (w_c >= 16'h0030) && (w_c <= 16'h0037);
        o_cls.oct_val   = w_c[2:0];
        case (w_c)
            16'h0061: o_cls.esc_code = 16'd7;
            16'h0062: o_cls.esc_code = 16'd8;
            16'h0066: o_cls.esc_code = 16'd12;
            16'h006E: o_cls.esc_code = 16'd10;
            16'h0072: o_cls.esc_code = 16'd13;
            16'h0074: o_cls.esc_code = 16'd9;
            16'h0076: o_cls.esc_code = 16'd11;
            default:  o_cls.esc_code = w_c;
        endcase
        if ((w_c >= 16'h0030) && (w_c <= 16'h0039)) begin
            o_cls.hex_ok  = 1'b1;
            o_cls.hex_val = w_c[3:0];
        end else if (((w_c >= 16'h0041) && (w_c <= 16'h0046)) ||
                     ((w_c >= 16'h0061) && (w_c <= 16'h0066))) begin
            o_cls.hex_ok  = 1'b1;
            o_cls.hex_val = w_c[3:0] + 4'd9;
        end
    end

endmodule

/* hdl/ced_queue.sv */
// ----------------------------------------------------------------------------
// ced_queue
// short queue of classified beats between front and back
// ----------------------------------------------------------------------------
module ced_queue import ced_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls      i_wdata,
    input  logic      i_pop,
    output t_cls      o_head,
    output t_q_status o_status
);

    t_cls              r_mem [C_Q_DEPTH];
    logic [C_Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [C_Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [C_Q_AW:0]   r_count, n_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (C_Q_AW+1)'(C_Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + C_Q_AW'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + C_Q_AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (C_Q_AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (C_Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

/* hdl/ced_back.sv */
// ----------------------------------------------------------------------------
// ced_back
// escape state machine, numeric accumulation and output beat register
// ----------------------------------------------------------------------------
module ced_back import ced_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cls      i_head,
    input  t_q_status i_status,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_acc, n_acc;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_out_valid;
    t_out_beat   r_out;
    logic        r_pend_valid;
    t_out_beat   r_pend;

    logic        w_load_ok;
    logic [1:0]  w_res_n;
    t_out_beat   w_res0, w_res1;

    assign w_load_ok   = !r_out_valid || i_out_ready;
    assign o_pop       = w_load_ok && !r_pend_valid && !i_status.empty;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    always_comb begin
        logic        d_ok;
        logic [3:0]  d_val;
        logic [2:0]  limit;
        logic [15:0] acc_next;
        logic [2:0]  cnt_next;
        t_idle_res   idle;
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        w_res_n  = 2'd0;
        w_res0   = '0;
        w_res1   = '0;
        d_ok     = 1'b0;
        d_val    = '0;
        limit    = C_LIMIT_HEX4;
        acc_next = '0;
        cnt_next = r_cnt + 3'd1;
        idle     = idle_step(i_head);
        case (r_mode)
            C_MODE_ESC: begin
                if (i_head.is_zero || i_head.is_x || i_head.is_u) begin
                    if (i_head.eoi) begin
                        w_res_n = 2'd1;
                        w_res0  = '{out_char: 16'd0, char_valid: 1'b1, end_of_output: 1'b1};
                        n_mode  = C_MODE_IDLE;
                        n_acc   = '0;
                        n_cnt   = '0;
                    end else begin
                        n_mode = i_head.is_zero ? C_MODE_OCT :
                                 i_head.is_x    ? C_MODE_HEX2 : C_MODE_HEX4;
                        n_acc  = '0;
                        n_cnt  = i_head.is_zero ? 3'd1 : 3'd0;
                    end
                end else begin
                    w_res_n = 2'd1;
                    w_res0  = '{out_char: i_head.esc_code, char_valid: 1'b1,
                                end_of_output: i_head.eoi};
                    n_mode  = C_MODE_IDLE;
                    n_acc   = '0;
                    n_cnt   = '0;
                end
            end
            C_MODE_OCT, C_MODE_HEX2, C_MODE_HEX4: begin
                if (r_mode == C_MODE_OCT) begin
                    d_ok     = i_head.oct_ok;
                    d_val    = {1'b0, i_head.oct_val};
                    limit    = C_LIMIT_OCT;
                    acc_next = {r_acc[12:0], 3'b000} | {12'd0, d_val};
                end else begin
                    d_ok     = i_head.hex_ok;
                    d_val    = i_head.hex_val;
                    limit    = (r_mode == C_MODE_HEX2) ? C_LIMIT_HEX2 : C_LIMIT_HEX4;
                    acc_next = {r_acc[11:0], 4'b0000} | {12'd0, d_val};
                end
                if (d_ok && (r_cnt < limit)) begin
                    n_acc = acc_next;
                    n_cnt = cnt_next;
                    if ((cnt_next >= limit) || i_head.eoi) begin
                        w_res_n = 2'd1;
                        w_res0  = '{out_char: acc_next, char_valid: 1'b1,
                                    end_of_output: i_head.eoi};
                        n_mode  = C_MODE_IDLE;
                        n_acc   = '0;
                        n_cnt   = '0;
                    end
                end else begin
                    w_res0  = '{out_char: r_acc, char_valid: 1'b1, end_of_output: 1'b0};
                    w_res1  = idle.beat;
                    w_res_n = idle.has_res ? 2'd2 : 2'd1;
                    n_mode  = idle.go_esc ? C_MODE_ESC : C_MODE_IDLE;
                    n_acc   = '0;
                    n_cnt   = '0;
                end
            end
            default: begin
                w_res0  = idle.beat;
                w_res_n = idle.has_res ? 2'd1 : 2'd0;
                n_mode  = idle.go_esc ? C_MODE_ESC : C_MODE_IDLE;
                n_acc   = '0;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= C_MODE_IDLE;
            r_acc        <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode <= n_mode;
                r_acc  <= n_acc;
                r_cnt  <= n_cnt;
            end
            if (w_load_ok) begin
                if (r_pend_valid) begin
                    r_out_valid  <= 1'b1;
                    r_pend_valid <= 1'b0;
                end else if (o_pop) begin
                    r_out_valid  <= (w_res_n != 2'd0);
                    r_pend_valid <= (w_res_n == 2'd2);
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_ok) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else if (o_pop) begin
                r_out  <= mask_beat(w_res0);
                r_pend <= mask_beat(w_res1);
            end
        end
    end

endmodule

/* hdl/ced_checker.sv */
// ----------------------------------------------------------------------------
// ced_checker
// port level checks on the escape sequence decoder
// ----------------------------------------------------------------------------
module ced_checker import ced_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_beat  i_in_beat,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_beat
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_beat))
        else $error("output beat changed while stalled");

    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.char_valid |->
            o_out_beat.end_of_output && (o_out_beat.out_char == 16'd0))
        else $error("bare end marker malformed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset did not clear output and queue");

endmodule

bind c_escape_sequence_decoder ced_checker u_checker (.*);
